// File: sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is held.
`define ODRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define ODRGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/odrgb_pkg.sv
// Package with the types, constants and channel math of the ordered dither block.
package odrgb_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_OUT_FORMAT,
        REG_FLIP_ROWS
    } t_reg_idx;

    localparam logic FMT_RGBA4444 = 1'b0;
    localparam logic FMT_RGB565   = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             flip;
    } t_geom_cfg;

    typedef struct packed {
        logic [3:0] weight_m1;
        logic       last;
    } t_pos_info;

    // Bayer weights minus one, indexed by {row[1:0], column[1:0]}.
    localparam logic [3:0] BAYER_M1 [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    // For weights 1..16 and drops of 2..4 bits, floor(2^drop * n / 17) equals
    // (n - 1) >> (4 - drop), so the offset is a plain shift of the table entry.
    function automatic logic [CH_W-1:0] dither_channel(
        input logic [CH_W-1:0] c,
        input logic [3:0]      m1,
        input logic [2:0]      drop
    );
        logic [CH_W:0]   sum;
        logic [CH_W-1:0] sat;
        sum = {1'b0, c} + ({5'b0, m1} >> (3'd4 - drop));
        sat = sum[CH_W] ? {CH_W{1'b1}} : sum[CH_W-1:0];
        return sat >> drop;
    endfunction

endpackage

// File: sv/odrgb_if.sv
// Valid/ready channel interfaces for input pixel words and result words.
interface odrgb_pix_if;
    import odrgb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface odrgb_res_if;
    import odrgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] packed_pixel;
    logic             last_of_image;

    modport source (output valid, output packed_pixel, output last_of_image, input ready);
    modport sink (input valid, input packed_pixel, input last_of_image, output ready);
endinterface

// File: sv/ordered_dither_rgb_to_16bit_core.sv
// Top level of the ordered dither converter from 8-bit RGBA to 16-bit pixels.
// A word accepted at the input passes through the input register and then the result register, which drives the output.
// Throughput: one word per cycle while the output is not stalled, set by the input register and the result register.
// Each stage holds its word while the stage after it is full and stalled.
// Reset is synchronous, active low: counters restart at the top-left pixel,
// both stages empty, width and height 1, RGBA4444, no row flipping.
module ordered_dither_rgb_to_16bit_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [odrgb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [odrgb_pkg::CFG_W-1:0]     i_cfg_data,
    odrgb_pix_if.sink                       i_pix,
    odrgb_res_if.source                     o_res
);
    import odrgb_pkg::*;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             r_fmt;
    logic             r_flip;

    t_geom_cfg        geom;
    t_pos_info        pos;
    logic             in_acc;
    logic             adv1;

    logic             r_v1;
    logic [CH_W-1:0]  r_red;
    logic [CH_W-1:0]  r_green;
    logic [CH_W-1:0]  r_blue;
    logic [CH_W-1:0]  r_alpha;
    logic [3:0]       r_weight_m1;
    logic             r_last1;

    logic [PIX_W-1:0] pix16;
    logic             r_v2;
    logic [PIX_W-1:0] r_pixel;
    logic             r_last2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1);
            r_height <= CFG_W'(1);
            r_fmt    <= FMT_RGBA4444;
            r_flip   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                REG_OUT_FORMAT:   r_fmt    <= i_cfg_data[0];
                REG_FLIP_ROWS:    r_flip   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign geom.width  = r_width;
    assign geom.height = r_height;
    assign geom.flip   = r_flip;

    assign adv1        = !r_v2 || o_res.ready;
    assign i_pix.ready = i_rst_n && (!r_v1 || adv1);
    assign in_acc      = i_pix.valid && i_pix.ready;

    odrgb_pos #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_acc),
        .i_geom  (geom),
        .o_pos   (pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_pix.ready) begin
            r_v1 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_red       <= i_pix.red;
            r_green     <= i_pix.green;
            r_blue      <= i_pix.blue;
            r_alpha     <= i_pix.alpha;
            r_weight_m1 <= pos.weight_m1;
            r_last1     <= pos.last;
        end
    end

    odrgb_pack u_pack (
        .i_red       (r_red),
        .i_green     (r_green),
        .i_blue      (r_blue),
        .i_alpha     (r_alpha),
        .i_weight_m1 (r_weight_m1),
        .i_format    (r_fmt),
        .o_pixel     (pix16)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv1) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_v1) begin
            r_pixel <= pix16;
            r_last2 <= r_last1;
        end
    end

    assign o_res.valid         = r_v2;
    assign o_res.packed_pixel  = r_pixel;
    assign o_res.last_of_image = r_last2;

endmodule

// File: sv/odrgb_pos.sv
// Column and row counters that pick the dither weight and flag the last pixel.
module odrgb_pos #(
    parameter int MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  odrgb_pkg::t_geom_cfg  i_geom,
    output odrgb_pkg::t_pos_info  o_pos
);
    import odrgb_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = (CFG_W > CNT_W + 1) ? CFG_W : CNT_W + 1;

    function automatic logic [CNT_W-1:0] last_index(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] e;
        e = CMP_W'(v);
        if (e == '0) begin
            e = CMP_W'(1);
        end else if (e > CMP_W'(MAX_DIM)) begin
            e = CMP_W'(MAX_DIM);
        end
        return CNT_W'(e - CMP_W'(1));
    endfunction

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic [CNT_W-1:0] w_last;
    logic [CNT_W-1:0] h_last;
    logic             end_col;
    logic             end_row;
    logic [1:0]       trow;

    always_comb begin
        w_last  = last_index(i_geom.width);
        h_last  = last_index(i_geom.height);
        end_col = (r_col >= w_last);
        end_row = (r_row >= h_last);
        trow    = i_geom.flip ? (h_last[1:0] - r_row[1:0]) : r_row[1:0];

        o_pos.weight_m1 = BAYER_M1[{trow, r_col[1:0]}];
        o_pos.last      = end_col && end_row;

        n_col = end_col ? '0 : r_col + 1'b1;
        if (end_col) begin
            n_row = end_row ? '0 : r_row + 1'b1;
        end else begin
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: sv/odrgb_pack.sv
// Per-channel dither, saturation, truncation and 16-bit packing.
module odrgb_pack (
    input  logic [odrgb_pkg::CH_W-1:0]  i_red,
    input  logic [odrgb_pkg::CH_W-1:0]  i_green,
    input  logic [odrgb_pkg::CH_W-1:0]  i_blue,
    input  logic [odrgb_pkg::CH_W-1:0]  i_alpha,
    input  logic [3:0]                  i_weight_m1,
    input  logic                        i_format,
    output logic [odrgb_pkg::PIX_W-1:0] o_pixel
);
    import odrgb_pkg::*;

    logic [CH_W-1:0] r4;
    logic [CH_W-1:0] g4;
    logic [CH_W-1:0] b4;
    logic [CH_W-1:0] r5;
    logic [CH_W-1:0] g6;
    logic [CH_W-1:0] b5;

    always_comb begin
        r4 = dither_channel(i_red,   i_weight_m1, 3'd4);
        g4 = dither_channel(i_green, i_weight_m1, 3'd4);
        b4 = dither_channel(i_blue,  i_weight_m1, 3'd4);
        r5 = dither_channel(i_red,   i_weight_m1, 3'd3);
        g6 = dither_channel(i_green, i_weight_m1, 3'd2);
        b5 = dither_channel(i_blue,  i_weight_m1, 3'd3);

        case (i_format)
            FMT_RGBA4444: begin
                o_pixel = {r4[3:0], g4[3:0], b4[3:0], i_alpha[7:4]};
            end
            FMT_RGB565: begin
                o_pixel = {r5[4:0], g6[5:0], b5[4:0]};
            end
            default: begin
                o_pixel = '0;
            end
        endcase
    end

endmodule

// File: sv/odrgb_chk.sv
// Port-level checker for the ordered dither converter and its bind statement.
`include "assert_macros.svh"

module odrgb_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [odrgb_pkg::PIX_W-1:0] i_out_pixel,
    input logic                        i_out_last
);

    `ODRGB_ASSERT_ALWAYS(a_reset_empties, i_clk, (!i_rst_n |=> !i_out_valid), "output valid after reset")

    `ODRGB_ASSERT(a_stall_holds, i_clk, i_rst_n, ((i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_pixel) && $stable(i_out_last))), "stalled output word changed")

    `ODRGB_ASSERT(a_backpressure_full, i_clk, i_rst_n, (!i_in_ready |-> i_out_valid), "input stalled while output is empty")

    `ODRGB_ASSERT(a_two_cycle_latency, i_clk, i_rst_n, ($rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2)), "output word without an input word two cycles earlier")

endmodule

bind ordered_dither_rgb_to_16bit_core odrgb_chk u_odrgb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_pixel (o_res.packed_pixel),
    .i_out_last  (o_res.last_of_image)
);
